### hdl/assert_macros.svh
// Assertion helpers; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/imht_pkg.sv
`default_nettype none
package imht_pkg;
  localparam int CAPACITY = 64;
  localparam int ID_SPACE = 1024;
  localparam int ID_W     = 10;
  localparam int TO_W     = 24;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MAP_AW   = $clog2(ID_SPACE);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_ADJUST = 3'd1,
    CMD_FIRE   = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_POP    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MAP, S_POPRD, S_RM, S_RM_RD,
    S_DN_RD, S_DN_C1, S_DN_C2, S_UP_RD, S_UP_CMP, S_PUT,
    S_FIN, S_DRAIN, S_DR_CHK, S_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } heap_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id;
    logic [TO_W-1:0] rem;
    status_t         st;
    logic            last;
  } res_t;

  // Wrap-safe ordering: a strictly before b.
  function automatic logic earlier(input logic [TIME_W-1:0] a,
                                   input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return d[TIME_W-1];
  endfunction
endpackage
`default_nettype wire

### hdl/indexed_min_heap_timer_unit.sv
`default_nettype none
// Indexed min-heap timer: up to 64 timers keyed by a 10-bit id, ordered by a
// wrap-safe 32-bit expiry against an internal millisecond counter that a tick
// command advances. Commands arrive one at a time on the in_* channel; every
// result (fired ids, then one status/report unless the last fire empties the
// heap, the final one flagged by last) leaves through a registered out_*
// channel. After reset the block clears the id map and holds in_ready low.
// Timing is set by the heap memory (one read port) walked by the sift
// sequencer: a sift-down level steps through S_DN_RD, S_DN_C1 and S_DN_C2, a
// sift-up level through S_UP_RD and S_UP_CMP; a removal reads the last slot
// into the gap and sifts it, and tick and next query repeat the removal per
// due timer.
`include "assert_macros.svh"
module indexed_min_heap_timer_unit
  import imht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        cmd,
  input  wire logic [ID_W-1:0]   id,
  input  wire logic [TO_W-1:0]   timeout_ms,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [ID_W-1:0]        fired_id,
  output logic [TO_W-1:0]        remaining_ms,
  output logic [1:0]             status,
  output logic                   last
);

  state_t state, state_next, ret;

  // Heap slots and id map live in synchronous memories.
  heap_t             heap_mem [CAPACITY];
  logic [SLOT_W:0]   map_mem  [ID_SPACE];
  heap_t             hrd;
  logic [SLOT_W:0]   map_rd;

  logic              heap_we, heap_re;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr;
  heap_t             heap_wdata;
  logic              map_we, map_re;
  logic [MAP_AW-1:0] map_waddr;
  logic [SLOT_W:0]   map_wdata;

  // Control and datapath registers.
  logic [MAP_AW-1:0] clr;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] now_ms;
  cmd_t              cmd_r;
  logic [ID_W-1:0]   tid;
  logic [TIME_W-1:0] exp_r;
  logic [SLOT_W-1:0] p;
  logic              moved;
  heap_t             cur, c1;
  logic [ID_W-1:0]   rm_id;
  res_t              pend;

  // Derived terms.
  logic [SLOT_W+1:0] c_idx, c2_idx, cnt_x;
  logic              has_c1, has_c2, pick2, down_swap, up_swap;
  heap_t             child;
  logic [SLOT_W-1:0] child_idx, par;
  logic [CNT_W-1:0]  lastp;
  logic              p_lt_last, found, full, due, out_load;
  logic [TIME_W-1:0] dlt;
  logic [TO_W-1:0]   rem_sat;

  assign c_idx     = {1'b0, p, 1'b1};
  assign c2_idx    = c_idx + 1'b1;
  assign cnt_x     = {1'b0, count};
  assign has_c1    = c_idx < cnt_x;
  assign has_c2    = c2_idx < cnt_x;
  assign pick2     = earlier(hrd.expiry, c1.expiry);
  assign child     = (state == S_DN_C2 && !pick2) ? c1 : hrd;
  assign child_idx = (state == S_DN_C2 && pick2) ? c2_idx[SLOT_W-1:0]
                                                 : c_idx[SLOT_W-1:0];
  assign down_swap = earlier(child.expiry, cur.expiry);
  assign up_swap   = earlier(cur.expiry, hrd.expiry);
  assign par       = (p - 1'b1) >> 1;
  assign lastp     = count - 1'b1;
  assign p_lt_last = {1'b0, p} < lastp;
  assign found     = map_rd[SLOT_W] && ({1'b0, map_rd[SLOT_W-1:0]} < count);
  assign full      = count >= CNT_W'(CAPACITY);
  assign dlt       = hrd.expiry - now_ms;
  assign due       = (dlt == '0) || dlt[TIME_W-1];
  assign rem_sat   = (|dlt[TIME_W-1:TO_W]) ? '1 : dlt[TO_W-1:0];
  assign out_load  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr == MAP_AW'(ID_SPACE - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_ADD, CMD_ADJUST, CMD_FIRE: state_next = S_MAP;
            CMD_TICK, CMD_NEXT:            state_next = S_DRAIN;
            CMD_POP: state_next = (count == '0) ? S_EMIT : S_POPRD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MAP: begin
        case (cmd_r)
          CMD_ADD:    state_next = found ? S_DN_RD : (full ? S_EMIT : S_UP_RD);
          CMD_ADJUST: state_next = found ? S_DN_RD : S_EMIT;
          default:    state_next = S_EMIT;
        endcase
      end
      S_POPRD:  state_next = S_RM;
      S_RM:     state_next = p_lt_last ? S_RM_RD : S_FIN;
      S_RM_RD:  state_next = S_DN_RD;
      S_DN_RD:  state_next = has_c1 ? S_DN_C1 : (moved ? S_PUT : S_UP_RD);
      S_DN_C1: begin
        if (has_c2)         state_next = S_DN_C2;
        else if (down_swap) state_next = S_DN_RD;
        else                state_next = moved ? S_PUT : S_UP_RD;
      end
      S_DN_C2:  state_next = down_swap ? S_DN_RD : (moved ? S_PUT : S_UP_RD);
      S_UP_RD:  state_next = (p == '0) ? S_PUT : S_UP_CMP;
      S_UP_CMP: state_next = up_swap ? S_UP_RD : S_PUT;
      S_PUT:    state_next = S_FIN;
      S_FIN: begin
        if (cmd_r == CMD_TICK || cmd_r == CMD_NEXT)
          state_next = (count == '0) ? S_IDLE : S_DRAIN;
        else
          state_next = S_EMIT;
      end
      S_DRAIN:  state_next = (count == '0) ? S_EMIT : S_DR_CHK;
      S_DR_CHK: state_next = S_EMIT;
      S_EMIT:   if (out_load) state_next = ret;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    heap_we    = 1'b0;
    heap_re    = 1'b0;
    heap_waddr = p;
    heap_raddr = '0;
    heap_wdata = cur;
    map_we     = 1'b0;
    map_re     = 1'b0;
    map_waddr  = cur.id;
    map_wdata  = {1'b1, p};
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_re  = in_valid;
        heap_re = in_valid && (cmd_t'(cmd) == CMD_POP);
      end
      S_DRAIN: heap_re = 1'b1;
      S_RM: begin
        map_we     = 1'b1;
        map_waddr  = rm_id;
        map_wdata  = '0;
        heap_re    = p_lt_last;
        heap_raddr = lastp[SLOT_W-1:0];
      end
      S_DN_RD: begin
        heap_re    = has_c1;
        heap_raddr = c_idx[SLOT_W-1:0];
      end
      S_DN_C1, S_DN_C2: begin
        if (state == S_DN_C1 && has_c2) begin
          heap_re    = 1'b1;
          heap_raddr = c2_idx[SLOT_W-1:0];
        end else if (down_swap) begin
          heap_we    = 1'b1;
          heap_wdata = child;
          map_we     = 1'b1;
          map_waddr  = child.id;
        end
      end
      S_UP_RD: begin
        heap_re    = (p != '0);
        heap_raddr = par;
      end
      S_UP_CMP: begin
        if (up_swap) begin
          heap_we    = 1'b1;
          heap_wdata = hrd;
          map_we     = 1'b1;
          map_waddr  = hrd.id;
        end
      end
      S_PUT: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (heap_re) hrd <= heap_mem[heap_raddr];
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd <= map_mem[id];
  end

  // Sequencer datapath and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      now_ms    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_load) begin
        out_valid    <= 1'b1;
        kind         <= pend.kind;
        fired_id     <= pend.id;
        remaining_ms <= pend.rem;
        status       <= pend.st;
        last         <= pend.last;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd_t'(cmd);
            tid   <= id;
            exp_r <= now_ms + {{(TIME_W-TO_W){1'b0}}, timeout_ms};
            moved <= 1'b0;
            if (cmd_t'(cmd) == CMD_TICK) now_ms <= now_ms + 1'b1;
            pend <= '{KIND_STATUS, '0, '0, ST_EMPTY, 1'b1};
            ret  <= S_IDLE;
          end
        end
        S_MAP: begin
          cur <= '{tid, exp_r};
          if (cmd_r == CMD_ADD && !found && !full) begin
            p     <= count[SLOT_W-1:0];
            count <= count + 1'b1;
          end else begin
            p <= map_rd[SLOT_W-1:0];
          end
          if (cmd_r == CMD_ADD && !found && full) begin
            pend <= '{KIND_STATUS, '0, '0, ST_FULL, 1'b1};
          end else if (cmd_r == CMD_FIRE && found) begin
            rm_id <= tid;
            pend  <= '{KIND_FIRED, tid, '0, ST_OK, 1'b0};
            ret   <= S_RM;
          end else begin
            pend <= '{KIND_STATUS, '0, '0, ST_UNKNOWN, 1'b1};
          end
        end
        S_POPRD: begin
          rm_id <= hrd.id;
          p     <= '0;
        end
        S_RM:    count <= count - 1'b1;
        S_RM_RD: cur <= hrd;
        S_DN_C1: begin
          c1 <= hrd;
          if (!has_c2 && down_swap) begin
            p     <= child_idx;
            moved <= 1'b1;
          end
        end
        S_DN_C2: begin
          if (down_swap) begin
            p     <= child_idx;
            moved <= 1'b1;
          end
        end
        S_UP_CMP: if (up_swap) p <= par;
        S_FIN: begin
          ret <= S_IDLE;
          if (cmd_r == CMD_POP) pend <= '{KIND_STATUS, rm_id, '0, ST_OK, 1'b1};
          else                  pend <= '{KIND_STATUS, '0, '0, ST_OK, 1'b1};
        end
        S_DRAIN: begin
          pend <= '{KIND_STATUS, '0, '0, ST_EMPTY, 1'b1};
          ret  <= S_IDLE;
        end
        S_DR_CHK: begin
          moved <= 1'b0;
          if (due) begin
            // last set when this removal empties the heap: no report follows
            pend  <= '{KIND_FIRED, hrd.id, '0, ST_OK, (count == CNT_W'(1))};
            ret   <= S_RM;
            rm_id <= hrd.id;
            p     <= '0;
          end else begin
            pend <= '{KIND_STATUS, '0, rem_sat, ST_OK, 1'b1};
            ret  <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_cap, count <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_tick_adv, in_valid && in_ready && cmd == CMD_TICK, now_ms == $past(now_ms) + 32'd1)
  `ASSERT_IMPLIES(a_put_in_range, state == S_PUT, {1'b0, p} < count)

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the indexed min-heap timer. A queue of commands is
// built per phase; a clocked driver presents them on the input channel and a
// clocked monitor compares every output transfer with the predicted results.
module tb_top
  import imht_pkg::*;
();

  typedef struct packed {
    logic [2:0]      cmd;
    logic [ID_W-1:0] id;
    logic [TO_W-1:0] tmo;
  } cmd_item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id;
    logic [TO_W-1:0] rem;
    logic [1:0]      st;
    logic            last;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] cmd = '0;
  logic [ID_W-1:0] id = '0;
  logic [TO_W-1:0] timeout_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [ID_W-1:0] fired_id;
  logic [TO_W-1:0] remaining_ms;
  logic [1:0] status;
  logic last;

  // idle/stall percentages, changed per phase by the stimulus block
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  cmd_item_t  pending_cmds[$];
  timer_res_t expected_results[$];
  int unsigned errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fires_seen = 0;
  longint unsigned cycle_count = 0;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  // predictor state
  logic [ID_W-1:0]   hp_id  [CAPACITY];
  logic [TIME_W-1:0] hp_exp [CAPACITY];
  logic [6:0]        id_map [ID_SPACE];
  int unsigned       hp_count;
  logic [TIME_W-1:0] clock_ms;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_min_heap_timer_unit dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .id, .timeout_ms,
    .out_valid, .out_ready, .kind, .fired_id, .remaining_ms, .status, .last
  );

  // ---------------------------------------------------------------- predictor
  function automatic bit exp_before(int unsigned a, int unsigned b);
    logic [TIME_W-1:0] d;
    d = hp_exp[a] - hp_exp[b];
    return d[TIME_W-1];
  endfunction

  function automatic bit head_due();
    logic [TIME_W-1:0] d;
    d = hp_exp[0] - clock_ms;
    return d == 0 || d[TIME_W-1];
  endfunction

  function automatic void put_slot(int unsigned s, logic [ID_W-1:0] t,
                                   logic [TIME_W-1:0] e);
    hp_id[s] = t;
    hp_exp[s] = e;
    id_map[t] = {1'b1, 6'(s)};
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [ID_W-1:0] ta;
    logic [TIME_W-1:0] ea;
    ta = hp_id[a];
    ea = hp_exp[a];
    put_slot(a, hp_id[b], hp_exp[b]);
    put_slot(b, ta, ea);
  endfunction

  function automatic void bubble_up(int unsigned p);
    int unsigned par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!exp_before(p, par)) break;
      swap_slots(p, par);
      p = par;
    end
  endfunction

  function automatic bit bubble_down(int unsigned p);
    int unsigned c;
    bit moved;
    moved = 0;
    forever begin
      c = 2 * p + 1;
      if (c >= hp_count) break;
      if (c + 1 < hp_count && exp_before(c + 1, c)) c++;
      if (!exp_before(c, p)) break;
      swap_slots(p, c);
      p = c;
      moved = 1;
    end
    return moved;
  endfunction

  function automatic void reorder(int unsigned p);
    if (!bubble_down(p)) bubble_up(p);
  endfunction

  function automatic void drop_slot(int unsigned p);
    int unsigned lastp;
    lastp = hp_count - 1;
    id_map[hp_id[p]] = '0;
    if (p < lastp) begin
      put_slot(p, hp_id[lastp], hp_exp[lastp]);
      hp_count--;
      reorder(p);
    end else begin
      hp_count--;
    end
  endfunction

  function automatic bit lookup_slot(logic [ID_W-1:0] t, output int unsigned s);
    s = id_map[t][5:0];
    return id_map[t][6] && s < hp_count;
  endfunction

  function automatic void push_result(logic k, logic [ID_W-1:0] t,
                                      logic [TO_W-1:0] r, status_t st, logic l);
    expected_results.insert(expected_results.size(),
                            timer_res_t'{kind: k, id: t, rem: r, st: st, last: l});
  endfunction

  // fire every due head entry, then the report (or flag the last fire)
  function automatic void expire_due();
    int unsigned n;
    logic [TIME_W-1:0] d;
    logic [TO_W-1:0] r;
    n = 0;
    while (hp_count > 0 && n < CAPACITY && head_due()) begin
      push_result(KIND_FIRED, hp_id[0], '0, ST_OK, 1'b0);
      n++;
      drop_slot(0);
    end
    if (hp_count > 0 || n == 0) begin
      r = '0;
      if (hp_count > 0 && !head_due()) begin
        d = hp_exp[0] - clock_ms;
        r = (d > 32'hFF_FFFF) ? 24'hFF_FFFF : d[TO_W-1:0];
      end
      push_result(KIND_STATUS, '0, r, hp_count > 0 ? ST_OK : ST_EMPTY, 1'b1);
    end else begin
      expected_results[$].last = 1'b1;
    end
  endfunction

  function automatic void predict_timer(cmd_item_t it);
    int unsigned s;
    logic [TIME_W-1:0] e;
    e = clock_ms + TIME_W'(it.tmo);
    case (it.cmd)
      CMD_ADD: begin
        if (lookup_slot(it.id, s)) begin
          hp_exp[s] = e;
          reorder(s);
          push_result(KIND_STATUS, '0, '0, ST_OK, 1'b1);
        end else if (hp_count >= CAPACITY) begin
          push_result(KIND_STATUS, '0, '0, ST_FULL, 1'b1);
        end else begin
          s = hp_count;
          put_slot(s, it.id, e);
          hp_count++;
          bubble_up(s);
          push_result(KIND_STATUS, '0, '0, ST_OK, 1'b1);
        end
      end
      CMD_ADJUST: begin
        if (!lookup_slot(it.id, s)) begin
          push_result(KIND_STATUS, '0, '0, ST_UNKNOWN, 1'b1);
        end else begin
          hp_exp[s] = e;
          reorder(s);
          push_result(KIND_STATUS, '0, '0, ST_OK, 1'b1);
        end
      end
      CMD_FIRE: begin
        if (!lookup_slot(it.id, s)) begin
          push_result(KIND_STATUS, '0, '0, ST_UNKNOWN, 1'b1);
        end else begin
          push_result(KIND_FIRED, it.id, '0, ST_OK, 1'b0);
          drop_slot(s);
          push_result(KIND_STATUS, '0, '0, ST_OK, 1'b1);
        end
      end
      CMD_TICK: begin
        clock_ms++;
        expire_due();
      end
      CMD_NEXT: expire_due();
      CMD_POP: begin
        if (hp_count == 0) begin
          push_result(KIND_STATUS, '0, '0, ST_EMPTY, 1'b1);
        end else begin
          push_result(KIND_STATUS, hp_id[0], '0, ST_OK, 1'b1);
          drop_slot(0);
        end
      end
      default: ; // undefined codes give no results
    endcase
  endfunction

  // ------------------------------------------------------------------- driver
  // Valid is only lowered after a transfer; it is never dropped then raised
  // in the same step.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_timer('{cmd: cmd, id: id, tmo: timeout_ms});
        cmds_sent <= cmds_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_item_t nx;
          nx = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= nx.cmd;
          id <= nx.id;
          timeout_ms <= nx.tmo;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (kind == KIND_FIRED) fires_seen <= fires_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d rem=%0d st=%0d last=%0d",
                 $time, kind, fired_id, remaining_ms, status, last);
        errors <= errors + 1;
      end else begin
        timer_res_t want;
        want = expected_results.pop_front();
        if (want.kind != kind || want.id != fired_id || want.rem != remaining_ms
            || want.st != status || want.last != last) begin
          $display("%0t: mismatch exp kind=%0d id=%0d rem=%0d st=%0d last=%0d",
                   $time, want.kind, want.id, want.rem, want.st, want.last);
          $display("%0t:          act kind=%0d id=%0d rem=%0d st=%0d last=%0d",
                   $time, kind, fired_id, remaining_ms, status, last);
          errors <= errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_cmd(cmd_t c, int unsigned t, int unsigned ms);
    pending_cmds.insert(pending_cmds.size(),
                        cmd_item_t'{cmd: c, id: ID_W'(t), tmo: TO_W'(ms)});
  endfunction

  function automatic void queue_raw(logic [2:0] c);
    pending_cmds.insert(pending_cmds.size(),
                        cmd_item_t'{cmd: c, id: ID_W'($urandom), tmo: TO_W'($urandom)});
  endfunction

  // mostly short timeouts so ticks make things expire; some huge ones
  function automatic int unsigned pick_tmo();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom & 24'hFF_FFFF;
      2: return 24'hFF_FFFF;
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned pool_base;
    int unsigned sel;
    for (int i = 0; i < ID_SPACE; i++) id_map[i] = '0;
    hp_count = 0;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-heap queries, extreme fields, re-arm, equal expiries
    queue_cmd(CMD_POP, 0, 0);
    queue_cmd(CMD_NEXT, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_FIRE, 1023, 0);
    queue_cmd(CMD_ADJUST, 5, 3);
    queue_cmd(CMD_ADD, 1023, 24'hFF_FFFF);
    queue_cmd(CMD_ADD, 0, 0);
    queue_cmd(CMD_ADD, 7, 2);
    queue_cmd(CMD_ADD, 8, 2);        // same expiry as id 7
    queue_cmd(CMD_ADD, 7, 1);        // re-arm
    queue_cmd(CMD_ADJUST, 1023, 5);
    queue_cmd(CMD_NEXT, 0, 0);       // id 0 due at once
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_FIRE, 1023, 0);
    queue_cmd(CMD_POP, 0, 0);
    queue_raw(3'd6);
    queue_raw(3'd7);
    queue_cmd(CMD_NEXT, 0, 0);
    wait_drained();

    // fill past capacity, tick twenty times, then pop four entries
    for (int i = 0; i < CAPACITY + 2; i++)
      queue_cmd(CMD_ADD, 100 + i, $urandom_range(40));
    for (int i = 0; i < 20; i++) queue_cmd(CMD_TICK, 0, 0);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_POP, 0, 0);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      pool_base = $urandom_range(ID_SPACE - 48);
      for (int i = 0; i < 56; i++) begin
        sel = $urandom_range(99);
        // ids from a small pool mostly, so commands hit live timers
        if (sel < 35)
          queue_cmd(CMD_ADD, pool_base + $urandom_range(47), pick_tmo());
        else if (sel < 45)
          queue_cmd(CMD_ADJUST, ($urandom_range(9) == 0) ? $urandom_range(1023)
                    : pool_base + $urandom_range(47), pick_tmo());
        else if (sel < 55)
          queue_cmd(CMD_FIRE, ($urandom_range(9) == 0) ? $urandom_range(1023)
                    : pool_base + $urandom_range(47), 0);
        else if (sel < 85)
          queue_cmd(CMD_TICK, $urandom, $urandom);
        else if (sel < 92)
          queue_cmd(CMD_NEXT, $urandom, $urandom);
        else if (sel < 98)
          queue_cmd(CMD_POP, $urandom, $urandom);
        else
          queue_raw(3'($urandom_range(6, 7)));
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("%0d commands sent, %0d results checked (%0d timer fires)",
             cmds_sent, results_seen, fires_seen);
    $display("covered full/empty heap, unknown ids, re-arm, idle and stall phases");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
